// ----- hw/rtl/hsvrgb_pkg.sv -----
package hsvrgb_pkg;

   localparam int HUE_W   = 9;
   localparam int CH_W    = 8;
   localparam int KEY_W   = HUE_W + 2 * CH_W;
   localparam int MUL_W   = 16;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int POS_W   = 6;
   localparam int FRAC_W  = 7;
   localparam int SEC_W   = 3;

   typedef logic [KEY_W-1:0] key_type;

   // red sits in the low byte so the packed struct maps straight onto tdata
   typedef struct packed {
      logic [CH_W-1:0] blue;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] red;
   } rgb_type;

   typedef struct packed {
      logic    hit;
      rgb_type rgb;
   } lookup_type;

   typedef struct packed {
      logic    we;
      key_type key;
      rgb_type rgb;
   } fill_type;

   localparam logic [HUE_W-1:0]  HUE_WRAP    = 9'd360;
   localparam logic [CH_W-1:0]   GRAY_SAT    = 8'd255;
   localparam logic [FRAC_W-1:0] SECTOR_SPAN = 7'd60;

   // floor(x / 60) == (x * 17477) >> 20, exact for x below 23831
   localparam logic [MUL_W-1:0]  RECIP_60    = 16'd17477;
   localparam int                RECIP_SHIFT = 20;

   // hue sectors
   localparam logic [SEC_W-1:0] SEC_R2Y = 3'd0;
   localparam logic [SEC_W-1:0] SEC_Y2G = 3'd1;
   localparam logic [SEC_W-1:0] SEC_G2C = 3'd2;
   localparam logic [SEC_W-1:0] SEC_C2B = 3'd3;
   localparam logic [SEC_W-1:0] SEC_B2M = 3'd4;
   localparam logic [SEC_W-1:0] SEC_M2R = 3'd5;

endpackage

// ----- hw/rtl/hsvrgb_mul.sv -----
module hsvrgb_mul
   import hsvrgb_pkg::*;
(
   input  logic              clock,
   input  logic              enable,
   input  logic [MUL_W-1:0]  op_a,
   input  logic [MUL_W-1:0]  op_b,
   output logic [PROD_W-1:0] prod
);

   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);

   // hold the last product while the sequencer waits
   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

// ----- hw/rtl/hsvrgb_cache.sv -----
module hsvrgb_cache
   import hsvrgb_pkg::*;
#(
   parameter int ENTRIES = 4
)
(
   input  logic       clock,
   input  logic       reset,
   input  key_type    lookup_key,
   output lookup_type lookup,
   input  fill_type   fill
);

   localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   key_type             key_ff   [ENTRIES];
   rgb_type             rgb_ff   [ENTRIES];
   logic [ENTRIES-1:0]  valid_ff;
   logic [ENTRIES-1:0]  valid_in;
   logic [SLOT_W-1:0]   slot_ff;
   logic [SLOT_W-1:0]   slot_in;

   // lowest matching slot wins
   always_comb begin
      lookup = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && key_ff[i] == lookup_key) begin
            lookup.hit = 1'b1;
            lookup.rgb = rgb_ff[i];
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      slot_in  = slot_ff;
      if (fill.we) begin
         valid_in[slot_ff] = 1'b1;
         if (slot_ff == SLOT_W'(ENTRIES - 1)) begin
            slot_in = '0;
         end else begin
            slot_in = slot_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         slot_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         slot_ff  <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fill.we) begin
         key_ff[slot_ff] <= fill.key;
         rgb_ff[slot_ff] <= fill.rgb;
      end
   end

endmodule

// ----- hw/rtl/hsv_to_rgb_cached_top.sv -----
// HSV to RGB converter with a small exact-match result cache. An item is
// accepted in one cycle and looked up in the cache the next; a hit, or a
// gray color (sat 255), delivers its result at the end of that lookup cycle.
// A colored miss makes four passes through one shared 16x16 multiplier
// (hue sector, base, ramp product, divide by 60 via reciprocal), one pass
// per cycle. No new item is taken until the current one leaves the
// sequencer. Results land in an output register, so the next item is taken
// while a finished result waits; a result still waiting when the following
// one is done holds the sequencer in its lookup or final state. On a miss
// the result is written to the cache slot picked round robin, and rsp_tuser
// reports whether the result came from the cache.
module hsv_to_rgb_cached_top
   import hsvrgb_pkg::*;
#(
   parameter int CACHE_ENTRIES = 4
)
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // hue[8:0], sat[16:9], value[24:17], zero pad

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // red[7:0], green[15:8], blue[23:16]
   output logic        rsp_tuser    // cache_hit
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_LOOK = 3'd1;
   localparam logic [2:0] ST_SECT = 3'd2;
   localparam logic [2:0] ST_BASE = 3'd3;
   localparam logic [2:0] ST_QUOT = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   logic [2:0]        state_ff,  state_in;
   logic [HUE_W-1:0]  hue_ff;
   logic [CH_W-1:0]   sat_ff,    val_ff;
   logic [SEC_W-1:0]  sector_ff, sector_in;
   logic [POS_W-1:0]  pos_ff,    pos_in;
   logic [CH_W-1:0]   base_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rgb_type           rsp_rgb_ff,   rsp_rgb_in;
   logic              rsp_hit_ff,   rsp_hit_in;

   logic              req_take;
   logic              out_free;
   logic [HUE_W-1:0]  hue_adj;
   logic [HUE_W-1:0]  sector_start;
   logic [CH_W-1:0]   diff;
   logic [FRAC_W-1:0] frac;
   logic [CH_W-1:0]   ramp;
   logic [MUL_W-1:0]  mul_a, mul_b;
   logic [PROD_W-1:0] prod;
   rgb_type           conv_rgb;
   rgb_type           gray_rgb;
   lookup_type        lookup;
   fill_type          fill;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign hue_adj      = (hue_ff >= HUE_WRAP) ? hue_ff - HUE_WRAP : hue_ff;
   assign sector_in    = prod[RECIP_SHIFT+SEC_W-1:RECIP_SHIFT];
   assign sector_start = HUE_W'(sector_in) * HUE_W'(SECTOR_SPAN);
   assign pos_in       = POS_W'(hue_adj - sector_start);
   assign diff         = val_ff - prod[2*CH_W-1:CH_W];
   assign frac         = sector_ff[0] ? SECTOR_SPAN - FRAC_W'(pos_ff) : FRAC_W'(pos_ff);
   assign ramp         = prod[RECIP_SHIFT+CH_W-1:RECIP_SHIFT] + base_ff;

   assign gray_rgb.red   = val_ff;
   assign gray_rgb.green = val_ff;
   assign gray_rgb.blue  = val_ff;

   // route the shared multiplier by step
   always_comb begin
      unique case (state_ff)
         ST_LOOK: begin
            mul_a = MUL_W'(hue_adj);
            mul_b = RECIP_60;
         end
         ST_SECT: begin
            mul_a = MUL_W'(sat_ff);
            mul_b = MUL_W'(val_ff);
         end
         ST_BASE: begin
            mul_a = MUL_W'(diff);
            mul_b = MUL_W'(frac);
         end
         ST_QUOT: begin
            mul_a = MUL_W'(prod[13:0]);
            mul_b = RECIP_60;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   hsvrgb_mul u_mul (
      .clock  (clock),
      .enable (state_ff != ST_DONE),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .prod   (prod)
   );

   hsvrgb_cache #(
      .ENTRIES (CACHE_ENTRIES)
   ) u_cache (
      .clock      (clock),
      .reset      (reset),
      .lookup_key ({hue_ff, sat_ff, val_ff}),
      .lookup     (lookup),
      .fill       (fill)
   );

   always_comb begin
      case (sector_ff)
         SEC_R2Y: begin
            conv_rgb.red = val_ff;  conv_rgb.green = ramp;    conv_rgb.blue = base_ff;
         end
         SEC_Y2G: begin
            conv_rgb.red = ramp;    conv_rgb.green = val_ff;  conv_rgb.blue = base_ff;
         end
         SEC_G2C: begin
            conv_rgb.red = base_ff; conv_rgb.green = val_ff;  conv_rgb.blue = ramp;
         end
         SEC_C2B: begin
            conv_rgb.red = base_ff; conv_rgb.green = ramp;    conv_rgb.blue = val_ff;
         end
         SEC_B2M: begin
            conv_rgb.red = ramp;    conv_rgb.green = base_ff; conv_rgb.blue = val_ff;
         end
         default: begin
            conv_rgb.red = val_ff;  conv_rgb.green = base_ff; conv_rgb.blue = ramp;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_rgb_in   = rsp_rgb_ff;
      rsp_hit_in   = rsp_hit_ff;
      fill.we      = 1'b0;
      fill.key     = {hue_ff, sat_ff, val_ff};
      fill.rgb     = conv_rgb;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (lookup.hit) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_rgb_in   = lookup.rgb;
                  rsp_hit_in   = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else if (sat_ff == GRAY_SAT) begin
               fill.rgb = gray_rgb;
               if (out_free) begin
                  fill.we      = 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_rgb_in   = gray_rgb;
                  rsp_hit_in   = 1'b0;
                  state_in     = ST_IDLE;
               end
            end else begin
               state_in = ST_SECT;
            end
         end
         ST_SECT: state_in = ST_BASE;
         ST_BASE: state_in = ST_QUOT;
         ST_QUOT: state_in = ST_DONE;
         ST_DONE: begin
            // hold the finished color until the output register frees up
            if (out_free) begin
               fill.we      = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_rgb_in   = conv_rgb;
               rsp_hit_in   = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         hue_ff <= req_tdata[HUE_W-1:0];
         sat_ff <= req_tdata[HUE_W+CH_W-1:HUE_W];
         val_ff <= req_tdata[HUE_W+2*CH_W-1:HUE_W+CH_W];
      end
      if (state_ff == ST_SECT) begin
         sector_ff <= sector_in;
         pos_ff    <= pos_in;
      end
      if (state_ff == ST_BASE) begin
         base_ff <= prod[2*CH_W-1:CH_W];
      end
      rsp_rgb_ff <= rsp_rgb_in;
      rsp_hit_ff <= rsp_hit_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_rgb_ff;
   assign rsp_tuser  = rsp_hit_ff;

`ifndef NO_ASSERTIONS
   a_done_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_tvalid && !rsp_tready) |=> (state_ff == ST_DONE))
      else $error("result dropped while output register was full");

   a_base_below_value: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BASE) |-> (prod[2*CH_W-1:CH_W] <= val_ff))
      else $error("base above value for a colored pixel");

   a_sector_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BASE) |-> (sector_ff <= SEC_M2R))
      else $error("hue sector out of range");

   a_ramp_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (ramp >= base_ff && ramp <= val_ff))
      else $error("ramp outside base..value");
`endif

endmodule
